// ===== hdl/format_string_expander_macros.svh =====
// ----------------------------------------------------------------------------
// format_string_expander_macros : assertion macros for the formatter checker
// Clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FORMAT_STRING_EXPANDER_MACROS_SVH
`define FORMAT_STRING_EXPANDER_MACROS_SVH

// Same-cycle implication.
`define FSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fse_pkg.sv =====
// ----------------------------------------------------------------------------
// fse_pkg : shared types and constants of the format string expander
// Command and status structs between controller and datapath, ASCII codes.
// ----------------------------------------------------------------------------
`default_nettype none

package fse_pkg;

  localparam int NUM_W      = 32;
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int COUNT_W    = 31;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [KIND_W-1:0] KIND_FORMAT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STRING = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INT    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd3;

  localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [BYTE_W-1:0] CH_S       = 8'h73;
  localparam logic [BYTE_W-1:0] CH_D       = 8'h64;
  localparam logic [BYTE_W-1:0] CH_X       = 8'h78;
  localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_A       = 8'h61;
  localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;

  typedef enum logic [1:0] {
    SRC_INPUT,
    SRC_MINUS,
    SRC_DIGIT
  } char_src_t;

  typedef struct packed {
    logic      push_char;
    char_src_t src;
    logic      push_count;
    logic      last;
    logic      load_dec;
    logic      load_hex;
    logic      conv_step;
    logic      digit_shift;
  } fse_cmd_t;

  typedef struct packed {
    logic can_push;
    logic neg;
    logic conv_done;
    logic top_zero;
    logic digit_one;
  } fse_status_t;

  function automatic logic [BYTE_W-1:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CH_ZERO + BYTE_W'(d);
    end else begin
      return CH_A + BYTE_W'(d - 4'd10);
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fse_ctrl.sv =====
// ----------------------------------------------------------------------------
// fse_ctrl : format parsing and sequencing state machine
// Tracks '%' and the pending conversion, steers the number datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fse_ctrl (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  input  wire  [fse_pkg::KIND_W-1:0]       kind,
  input  wire  [fse_pkg::BYTE_W-1:0]       char_byte,
  input  fse_pkg::fse_status_t             status,
  output logic                             in_ready,
  output fse_pkg::fse_cmd_t                cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_S,
    PEND_D,
    PEND_X
  } pend_t;

  state_t state_r,   state_nxt;
  pend_t  pending_r, pending_nxt;
  logic   percent_r, percent_nxt;
  logic   started_r, started_nxt;
  logic   accept;

  always_comb begin
    state_nxt   = state_r;
    pending_nxt = pending_r;
    percent_nxt = percent_r;
    started_nxt = started_r;
    cmd         = '0;
    cmd.src     = fse_pkg::SRC_INPUT;
    in_ready    = (state_r == ST_IDLE) && status.can_push;
    accept      = in_valid && in_ready;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            fse_pkg::KIND_FORMAT: begin
              pending_nxt = PEND_NONE;
              if (percent_r) begin
                percent_nxt = 1'b0;
                case (char_byte)
                  fse_pkg::CH_S: pending_nxt = PEND_S;
                  fse_pkg::CH_D: pending_nxt = PEND_D;
                  fse_pkg::CH_X: pending_nxt = PEND_X;
                  default:       pending_nxt = PEND_NONE;
                endcase
              end else if (char_byte == fse_pkg::CH_PERCENT) begin
                percent_nxt = 1'b1;
              end else if (char_byte != fse_pkg::CH_NUL) begin
                cmd.push_char = 1'b1;
                cmd.last      = 1'b1;
              end
            end
            fse_pkg::KIND_STRING: begin
              if (pending_r == PEND_S) begin
                if (char_byte == fse_pkg::CH_NUL) begin
                  pending_nxt = PEND_NONE;
                end else begin
                  cmd.push_char = 1'b1;
                  cmd.last      = 1'b1;
                end
              end
            end
            fse_pkg::KIND_INT: begin
              started_nxt = 1'b0;
              if (pending_r == PEND_D) begin
                pending_nxt  = PEND_NONE;
                cmd.load_dec = 1'b1;
                state_nxt    = ST_SIGN;
              end else if (pending_r == PEND_X) begin
                pending_nxt  = PEND_NONE;
                cmd.load_hex = 1'b1;
                state_nxt    = ST_EMIT;
              end
            end
            fse_pkg::KIND_END: begin
              cmd.push_count = 1'b1;
              cmd.last       = 1'b1;
              percent_nxt    = 1'b0;
              pending_nxt    = PEND_NONE;
            end
            default: begin
              pending_nxt = pending_r;
            end
          endcase
        end
      end
      ST_SIGN: begin
        if (!status.neg) begin
          state_nxt = ST_CONV;
        end else if (status.can_push) begin
          cmd.push_char = 1'b1;
          cmd.src       = fse_pkg::SRC_MINUS;
          state_nxt     = ST_CONV;
        end
      end
      ST_CONV: begin
        if (status.conv_done) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.conv_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!started_r && status.top_zero && !status.digit_one) begin
          cmd.digit_shift = 1'b1;
        end else if (status.can_push) begin
          cmd.push_char   = 1'b1;
          cmd.src         = fse_pkg::SRC_DIGIT;
          cmd.digit_shift = 1'b1;
          cmd.last        = status.digit_one;
          started_nxt     = 1'b1;
          if (status.digit_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pending_r <= PEND_NONE;
      percent_r <= 1'b0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pending_r <= pending_nxt;
      percent_r <= percent_nxt;
      started_r <= started_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fse_dp.sv =====
// ----------------------------------------------------------------------------
// fse_dp : number conversion, character counter and output register
// Shift-add-3 binary to BCD, one bit a cycle; digits leave from the top.
// ----------------------------------------------------------------------------
`default_nettype none

module fse_dp #(
  parameter int NUMBER_BITS = 32
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  fse_pkg::fse_cmd_t                cmd,
  output fse_pkg::fse_status_t             status,
  input  wire  [fse_pkg::BYTE_W-1:0]       char_byte,
  input  wire  [fse_pkg::NUM_W-1:0]        number,
  input  wire                              out_ready,
  output logic                             out_valid,
  output logic [fse_pkg::BYTE_W-1:0]       out_byte,
  output logic                             out_is_count,
  output logic [fse_pkg::COUNT_W-1:0]      out_count,
  output logic                             out_last
);

  localparam int NB        = NUMBER_BITS;
  // decimal digits of 2**NB - 1; always at least the hex digit count
  localparam int NDIG      = (NB * 1233) / 4096 + 1;
  localparam int DW        = NDIG * 4;
  localparam int BIT_CNT_W = $clog2(NB + 1);
  localparam int DIG_CNT_W = $clog2(NDIG + 1);

  logic [NB-1:0]                 num_nb;
  logic [NB-1:0]                 mag;
  logic [NB-1:0]                 val_r;
  logic [DW-1:0]                 bcd_r;
  logic [DW-1:0]                 bcd_adj;
  logic [3:0]                    dig;
  logic [BIT_CNT_W-1:0]          bit_cnt_r;
  logic [DIG_CNT_W-1:0]          dig_cnt_r;
  logic                          neg_r;
  logic [3:0]                    top_dig;
  logic                          out_valid_r, out_valid_nxt;
  logic [fse_pkg::BYTE_W-1:0]    out_byte_r;
  logic                          out_is_count_r;
  logic [fse_pkg::COUNT_W-1:0]   out_count_r;
  logic                          out_last_r;
  logic [fse_pkg::COUNT_W-1:0]   char_count_r, char_count_nxt;
  logic [fse_pkg::BYTE_W-1:0]    char_sel;

  generate
    if (NB <= fse_pkg::NUM_W) begin : g_trunc
      assign num_nb = number[NB-1:0];
    end else begin : g_ext
      assign num_nb = {{(NB - fse_pkg::NUM_W){1'b0}}, number};
    end
  endgenerate

  assign mag     = num_nb[NB-1] ? (~num_nb + NB'(1)) : num_nb;
  assign top_dig = bcd_r[DW-1 -: 4];

  always_comb begin
    bcd_adj = '0;
    dig     = '0;
    for (int i = 0; i < NDIG; i++) begin
      dig             = bcd_r[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (dig >= 4'd5) ? (dig + 4'd3) : dig;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_dec) begin
      val_r     <= mag;
      neg_r     <= num_nb[NB-1];
      bcd_r     <= '0;
      bit_cnt_r <= BIT_CNT_W'(NB);
      dig_cnt_r <= DIG_CNT_W'(NDIG);
    end else if (cmd.load_hex) begin
      neg_r     <= 1'b0;
      bcd_r     <= DW'(num_nb);
      bit_cnt_r <= '0;
      dig_cnt_r <= DIG_CNT_W'(NDIG);
    end else if (cmd.conv_step) begin
      bcd_r     <= {bcd_adj[DW-2:0], val_r[NB-1]};
      val_r     <= val_r << 1;
      bit_cnt_r <= bit_cnt_r - BIT_CNT_W'(1);
    end else if (cmd.digit_shift) begin
      bcd_r     <= bcd_r << 4;
      dig_cnt_r <= dig_cnt_r - DIG_CNT_W'(1);
    end
  end

  always_comb begin
    case (cmd.src)
      fse_pkg::SRC_INPUT: char_sel = char_byte;
      fse_pkg::SRC_MINUS: char_sel = fse_pkg::CH_MINUS;
      fse_pkg::SRC_DIGIT: char_sel = fse_pkg::digit_char(top_dig);
      default:            char_sel = char_byte;
    endcase
  end

  assign status.can_push  = !out_valid_r || out_ready;
  assign status.neg       = neg_r;
  assign status.conv_done = (bit_cnt_r == '0);
  assign status.top_zero  = (top_dig == 4'd0);
  assign status.digit_one = (dig_cnt_r == DIG_CNT_W'(1));

  always_comb begin
    char_count_nxt = char_count_r;
    if (cmd.push_count) begin
      char_count_nxt = '0;
    end else if (cmd.push_char && !(&char_count_r)) begin
      char_count_nxt = char_count_r + fse_pkg::COUNT_W'(1);
    end
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.push_char || cmd.push_count) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      char_count_r <= '0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      char_count_r <= char_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_count) begin
      out_byte_r     <= '0;
      out_is_count_r <= 1'b1;
      out_count_r    <= char_count_r;
      out_last_r     <= 1'b1;
    end else if (cmd.push_char) begin
      out_byte_r     <= char_sel;
      out_is_count_r <= 1'b0;
      out_count_r    <= '0;
      out_last_r     <= cmd.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_is_count = out_is_count_r;
  assign out_count    = out_count_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/format_string_expander.sv =====
// Format, string and end results reach the output register the cycle after acceptance.
// Format, string and end-of-call transactions: one per cycle while the output drains.
// %x: DIG = floor(NUMBER_BITS*log10(2))+1 digit slots (10 at 32 bits), one a cycle unless stalled.
// %d: optional minus sign, bit-serial BCD conversion of NUMBER_BITS bits, then digits as %x.
// Reset (rst_n low, synchronous): no '%' pending, no conversion, count zero, output empty.
// ----------------------------------------------------------------------------
// format_string_expander : stream formatter with %s, %d and %x conversions
// Copies format bytes, passes string arguments, expands integer arguments
// to ASCII and reports the character count at the end of each call.
// ----------------------------------------------------------------------------
`default_nettype none

module format_string_expander #(
  parameter int NUMBER_BITS = 32   // bits of the integer argument used, 8 to 64
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // input channel
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [fse_pkg::IN_DATA_W-1:0]       in_tdata,   // [7:0] char_byte, [39:8] number
  input  wire  [fse_pkg::KIND_W-1:0]          in_tuser,   // [1:0] kind
  // result channel
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [fse_pkg::OUT_DATA_W-1:0]      out_tdata,  // [7:0] out_byte, [38:8] count, [39] zero
  output logic                                out_tuser,  // [0] is_count
  output logic                                out_tlast   // last result of the transaction
);

  // Field split of the input transaction
  logic [fse_pkg::BYTE_W-1:0]  char_byte;
  logic [fse_pkg::NUM_W-1:0]   number;

  assign char_byte = in_tdata[fse_pkg::BYTE_W-1:0];
  assign number    = in_tdata[fse_pkg::BYTE_W +: fse_pkg::NUM_W];

  fse_pkg::fse_cmd_t      cmd;
  fse_pkg::fse_status_t   status;

  logic [fse_pkg::BYTE_W-1:0]   out_byte;
  logic [fse_pkg::COUNT_W-1:0]  out_count;

  // Controller: parses the format stream and sequences each conversion.
  // It only takes a transaction when the output register can take a result,
  // so the one character a plain byte makes never waits inside the block.
  fse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .kind      (in_tuser),
    .char_byte (char_byte),
    .status    (status),
    .in_ready  (in_tready),
    .cmd       (cmd)
  );

  // Datapath: BCD converter, digit shifter, saturating count, output register.
  fse_dp #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .char_byte    (char_byte),
    .number       (number),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_byte     (out_byte),
    .out_is_count (out_tuser),
    .out_count    (out_count),
    .out_last     (out_tlast)
  );

  // Pack the result: byte low, count above it, pad bit on top
  assign out_tdata = {1'b0, out_count, out_byte};

endmodule

`default_nettype wire

// ===== hdl/fse_checker.sv =====
// ----------------------------------------------------------------------------
// fse_checker : port-level checks on the format string expander
// Bound to the top level; watches the stream ports only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "format_string_expander_macros.svh"

module fse_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tvalid,
  input wire                             in_tready,
  input wire [fse_pkg::KIND_W-1:0]       in_tuser,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [fse_pkg::OUT_DATA_W-1:0]   out_tdata,
  input wire                             out_tuser,
  input wire                             out_tlast
);

  logic in_fire;

  assign in_fire = in_tvalid && in_tready;

  `FSE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `FSE_ASSERT_NEXT(a_end_count, in_fire && in_tuser == fse_pkg::KIND_END, out_tvalid && out_tuser && out_tlast, "end of call gave no count result")
  `FSE_ASSERT_NOW(a_count_form, out_tvalid && out_tuser, out_tlast && out_tdata[7:0] == 8'd0, "count result malformed")
  `FSE_ASSERT_NOW(a_char_form, out_tvalid && !out_tuser, out_tdata[39:8] == 32'd0 && out_tdata[7:0] != 8'd0, "character result malformed")

endmodule

bind format_string_expander fse_checker u_fse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== verif/tb_format_string_expander.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_format_string_expander : self-checking bench for the stream formatter
// Drives format, string, integer and end-of-call transactions with random
// idle cycles on both sides. Predicts every output character and count
// inside the bench and checks each output transaction against them in order.
// ----------------------------------------------------------------------------
module tb_format_string_expander;

  localparam int    DRAIN_CYCLES = 60;   // longest %d expansion plus margin
  localparam int    HOLD_CYCLES  = 300;
  localparam int    RANDOM_ITEMS = 150;
  localparam string DIGIT_SET    = "0123456789abcdef";

  typedef enum logic [1:0] {
    CONV_NONE,
    CONV_STR,
    CONV_DEC,
    CONV_HEX
  } conv_t;

  typedef struct {
    logic [fse_pkg::BYTE_W-1:0]  out_byte;
    logic                        is_count;
    logic [fse_pkg::COUNT_W-1:0] count;
    logic                        last;
  } fmt_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [fse_pkg::IN_DATA_W-1:0]  in_tdata;   // [7:0] char_byte, [39:8] number
  logic [fse_pkg::KIND_W-1:0]     in_tuser;   // [1:0] kind
  logic                           out_tvalid;
  logic                           out_tready;
  logic [fse_pkg::OUT_DATA_W-1:0] out_tdata;  // [7:0] out_byte, [38:8] count, [39] zero
  logic                           out_tuser;  // [0] is_count
  logic                           out_tlast;

  // predictor state
  logic                           fmt_percent;
  conv_t                          fmt_conv;
  logic [fse_pkg::COUNT_W-1:0]    fmt_chars;
  fmt_result_t                    expected_output[$];

  bit                    gaps_on = 1'b1;
  int                    hold_off_cycles = 0;
  int                    n_errors = 0;
  int                    items_sent = 0;
  int                    results_checked = 0;

  format_string_expander u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void push_char(input logic [fse_pkg::BYTE_W-1:0] c);
    fmt_result_t r;
    r.out_byte = c;
    r.is_count = 1'b0;
    r.count    = '0;
    r.last     = 1'b0;
    expected_output.push_back(r);
    if (fmt_chars != {fse_pkg::COUNT_W{1'b1}}) fmt_chars++;
  endfunction

  function automatic void expand_item(input logic [fse_pkg::KIND_W-1:0] kind,
                                      input logic [fse_pkg::BYTE_W-1:0] ch,
                                      input logic [fse_pkg::NUM_W-1:0]  num);
    int                          produced;
    logic [fse_pkg::NUM_W-1:0]   mag;
    logic [fse_pkg::BYTE_W-1:0]  digits[$];
    bit                          is_dec;
    int                          radix;
    fmt_result_t                 r;
    produced = 0;
    case (kind)
      fse_pkg::KIND_FORMAT: begin
        fmt_conv = CONV_NONE;
        if (fmt_percent) begin
          fmt_percent = 1'b0;
          if (ch == fse_pkg::CH_S) fmt_conv = CONV_STR;
          else if (ch == fse_pkg::CH_D) fmt_conv = CONV_DEC;
          else if (ch == fse_pkg::CH_X) fmt_conv = CONV_HEX;
        end else if (ch == fse_pkg::CH_PERCENT) begin
          fmt_percent = 1'b1;
        end else if (ch != fse_pkg::CH_NUL) begin
          push_char(ch);
          produced++;
        end
      end
      fse_pkg::KIND_STRING: begin
        if (fmt_conv == CONV_STR) begin
          if (ch == fse_pkg::CH_NUL) fmt_conv = CONV_NONE;
          else begin
            push_char(ch);
            produced++;
          end
        end
      end
      fse_pkg::KIND_INT: begin
        if (fmt_conv == CONV_DEC || fmt_conv == CONV_HEX) begin
          is_dec   = (fmt_conv == CONV_DEC);
          radix    = is_dec ? 10 : 16;
          fmt_conv = CONV_NONE;
          mag      = num;
          if (is_dec && num[fse_pkg::NUM_W-1]) begin
            push_char(fse_pkg::CH_MINUS);
            produced++;
            mag = -num;  // unsigned magnitude, so the most negative value prints in full
          end
          do begin
            digits.push_front(DIGIT_SET[int'(mag % radix)]);
            mag = mag / radix;
          end while (mag != 0);
          foreach (digits[i]) begin
            push_char(digits[i]);
            produced++;
          end
        end
      end
      default: begin  // end of call
        r.out_byte = '0;
        r.is_count = 1'b1;
        r.count    = fmt_chars;
        r.last     = 1'b0;
        expected_output.push_back(r);
        produced    = 1;
        fmt_chars   = '0;
        fmt_percent = 1'b0;
        fmt_conv    = CONV_NONE;
      end
    endcase
    if (produced > 0) expected_output[expected_output.size()-1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one transaction per call, random lead-in gap
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [fse_pkg::KIND_W-1:0] kind,
                           input logic [fse_pkg::BYTE_W-1:0] ch,
                           input logic [fse_pkg::NUM_W-1:0] num);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {num, ch};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    expand_item(kind, ch, num);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(fse_pkg::KIND_FORMAT, s[i], $urandom());
  endtask

  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    while (expected_output.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [fse_pkg::NUM_W-1:0] pick_number();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3:       return 32'hffff_ffff;
      4:       return $urandom_range(0, 99);
      default: return $urandom();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = gaps_on ? $urandom_range(0, 9) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    fmt_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_output.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected output transaction, expected none,", $time,
                 " actual data %h user %b last %b", out_tdata, out_tuser, out_tlast);
      end else begin
        want = expected_output.pop_front();
        results_checked++;
        if (out_tdata[7:0] !== want.out_byte) begin
          n_errors++;
          $display("%0t: out_byte mismatch, expected %h actual %h",
                   $time, want.out_byte, out_tdata[7:0]);
        end
        if (out_tuser !== want.is_count) begin
          n_errors++;
          $display("%0t: is_count mismatch, expected %b actual %b",
                   $time, want.is_count, out_tuser);
        end
        if (out_tdata[38:8] !== want.count) begin
          n_errors++;
          $display("%0t: count mismatch, expected %0d actual %0d",
                   $time, want.count, out_tdata[38:8]);
        end
        if (out_tdata[39] !== 1'b0) begin
          n_errors++;
          $display("%0t: padding bit mismatch, expected 0 actual %b", $time, out_tdata[39]);
        end
        if (out_tlast !== want.last) begin
          n_errors++;
          $display("%0t: last mismatch, expected %b actual %b", $time, want.last, out_tlast);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_plain_bytes();
    send_item(fse_pkg::KIND_FORMAT, fse_pkg::CH_NUL, 32'hffff_ffff);  // zero byte: dropped
    send_item(fse_pkg::KIND_FORMAT, 8'hff, 32'hffff_ffff);
    send_item(fse_pkg::KIND_FORMAT, 8'h01, '0);
  endtask

  task automatic test_string_arg();
    send_text("%s");
    send_item(fse_pkg::KIND_STRING, 8'h68, '0);
    send_item(fse_pkg::KIND_STRING, 8'hff, 32'hffff_ffff);
    send_item(fse_pkg::KIND_STRING, fse_pkg::CH_NUL, '0);           // terminator ends %s
  endtask

  task automatic test_int_args();
    send_text("%d");
    send_item(fse_pkg::KIND_INT, 8'hff, 32'h8000_0000);             // most negative
    send_text("%x");
    send_item(fse_pkg::KIND_INT, '0, 32'hffff_ffff);
  endtask

  task automatic test_odd_selectors();
    send_text("%%");                                      // selector '%' prints nothing
    send_item(fse_pkg::KIND_INT, '0, 32'd5);              // nothing pending
    send_text("%s");
    send_item(fse_pkg::KIND_INT, '0, 32'd7);              // wrong kind, %s kept
    send_item(fse_pkg::KIND_STRING, 8'h7a, '0);
    send_item(fse_pkg::KIND_FORMAT, 8'h42, '0);           // missing argument: %s dropped
    send_item(fse_pkg::KIND_STRING, 8'h71, '0);           // now ignored
    send_item(fse_pkg::KIND_FORMAT, fse_pkg::CH_PERCENT, '0);
    send_item(fse_pkg::KIND_FORMAT, fse_pkg::CH_NUL, '0); // zero selector
    send_item(fse_pkg::KIND_END, '0, '0);
  endtask

  task automatic test_random_calls();
    int start;
    int n;
    logic [fse_pkg::BYTE_W-1:0] sel;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      // a stretch in the middle runs with no idle cycles on either side
      n = items_sent - start;
      gaps_on = (n < 80 || n >= 120);
      case ($urandom_range(0, 11))
        0, 1, 2: send_item(fse_pkg::KIND_FORMAT, fse_pkg::BYTE_W'($urandom_range(1, 255)),
                           $urandom());
        3, 4: begin
          send_text("%s");
          repeat ($urandom_range(0, 5)) begin
            send_item(fse_pkg::KIND_STRING, fse_pkg::BYTE_W'($urandom_range(1, 255)),
                      $urandom());
          end
          send_item(fse_pkg::KIND_STRING, fse_pkg::CH_NUL, $urandom());
        end
        5, 6: begin
          send_text("%d");
          send_item(fse_pkg::KIND_INT, fse_pkg::BYTE_W'($urandom()), pick_number());
        end
        7, 8: begin
          send_text("%x");
          send_item(fse_pkg::KIND_INT, fse_pkg::BYTE_W'($urandom()), pick_number());
        end
        9: send_item(fse_pkg::KIND_W'($urandom_range(0, 3)), fse_pkg::BYTE_W'($urandom()),
                     $urandom());
        10: begin
          // broken sequence: a conversion followed by a random format byte or argument of either kind
          case ($urandom_range(0, 2))
            0:       sel = fse_pkg::CH_S;
            1:       sel = fse_pkg::CH_D;
            default: sel = fse_pkg::CH_X;
          endcase
          send_item(fse_pkg::KIND_FORMAT, fse_pkg::CH_PERCENT, $urandom());
          send_item(fse_pkg::KIND_FORMAT, sel, $urandom());
          send_item(fse_pkg::KIND_W'($urandom_range(0, 2)), fse_pkg::BYTE_W'($urandom()),
                    $urandom());
        end
        default: send_item(fse_pkg::KIND_END, fse_pkg::BYTE_W'($urandom()), $urandom());
      endcase
    end
    gaps_on = 1'b1;
    send_item(fse_pkg::KIND_END, '0, '0);
  endtask

  task automatic test_output_hold_off();
    wait_for_idle();
    hold_off_cycles = HOLD_CYCLES;
    gaps_on = 1'b0;
    repeat (6) begin
      send_text("ab%d");
      send_item(fse_pkg::KIND_INT, '0, 32'h8000_0000);
    end
    send_item(fse_pkg::KIND_END, '0, '0);
    gaps_on = 1'b1;
  endtask

  initial begin
    fmt_percent = 1'b0;
    fmt_conv    = CONV_NONE;
    fmt_chars   = '0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_plain_bytes();
    test_string_arg();
    test_int_args();
    test_odd_selectors();
    test_random_calls();
    test_output_hold_off();
    wait_for_idle();

    $display("Sent %0d input transactions and checked %0d output transactions,",
             items_sent, results_checked);
    $display("covering %%s, %%d and %%x, odd selectors, stray arguments and a long output stall.");
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
